// ----- hdl/urfo_pkg.sv -----
// ----------------------------------------------------------------------------
// urfo_pkg
// Shared types and constants of the UART receive FIFO with overrun counter.
// ----------------------------------------------------------------------------
`default_nettype none

package urfo_pkg;

	// Ring storage depth; the ring holds at most RING_DEPTH-1 bytes
	localparam int RING_DEPTH = 256;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 16;

	// Stream widths
	localparam int S_TDATA_W  = 16;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 32;

	// Action codes
	typedef logic [S_TUSER_W-1:0] action_t;
	localparam action_t ACT_RECEIVE = 2'd0;
	localparam action_t ACT_READ    = 2'd1;
	localparam action_t ACT_CLEAR   = 2'd2;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Control to datapath: storage access and result fields of one item
	typedef struct packed {
		logic  wr_en;
		ptr_t  wr_addr;
		byte_t wr_data;
		logic  rd_en;
		ptr_t  rd_addr;
		logic  ring_nonempty;
		logic  read_valid;
		logic  data_ready;
		cnt_t  overrun_total;
	} ctrl_t;

	// Advance a ring pointer, wrapping at the last entry
	function automatic ptr_t ptr_advance(input ptr_t p);
		ptr_t nxt;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = p + ptr_t'(1);
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/urfo_ram.sv -----
// ----------------------------------------------------------------------------
// urfo_ram
// Generic single-write, single-read RAM with registered, enabled read port.
// ----------------------------------------------------------------------------
`default_nettype none

module urfo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/urfo_ctrl.sv -----
// ----------------------------------------------------------------------------
// urfo_ctrl
// Ring pointers and overrun counter; decodes one item into storage access
// and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module urfo_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire urfo_pkg::action_t action,
	input  wire urfo_pkg::byte_t  rx_byte,
	input  wire logic             byte_present,
	input  wire logic             hw_overrun,
	output urfo_pkg::ctrl_t       ctrl
);

	urfo_pkg::ptr_t wr_ptr_q, rd_ptr_q, wr_ptr_nxt, rd_ptr_nxt, wr_ptr_inc;
	urfo_pkg::cnt_t cnt_q, cnt_nxt;
	logic           full, nonempty, push, pop;

	assign wr_ptr_inc = urfo_pkg::ptr_advance(wr_ptr_q);
	assign full       = (wr_ptr_inc == rd_ptr_q);
	assign nonempty   = (wr_ptr_q != rd_ptr_q);

	always_comb begin
		push       = 1'b0;
		pop        = 1'b0;
		wr_ptr_nxt = wr_ptr_q;
		rd_ptr_nxt = rd_ptr_q;
		cnt_nxt    = cnt_q;
		case (action)
			urfo_pkg::ACT_RECEIVE: begin
				push    = byte_present && !full;
				// count the flag, then a dropped byte on a full ring
				cnt_nxt = cnt_q + urfo_pkg::cnt_t'(hw_overrun)
					+ urfo_pkg::cnt_t'(byte_present && full);
				if (push) begin
					wr_ptr_nxt = wr_ptr_inc;
				end
			end
			urfo_pkg::ACT_READ: begin
				pop = nonempty;
				if (pop) begin
					rd_ptr_nxt = urfo_pkg::ptr_advance(rd_ptr_q);
				end
			end
			urfo_pkg::ACT_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctrl.wr_en         = accept && push;
		ctrl.wr_addr       = wr_ptr_q;
		ctrl.wr_data       = rx_byte;
		ctrl.rd_en         = accept && pop;
		ctrl.rd_addr       = rd_ptr_q;
		ctrl.ring_nonempty = nonempty;
		ctrl.read_valid    = pop;
		ctrl.data_ready    = (wr_ptr_nxt != rd_ptr_nxt);
		ctrl.overrun_total = cnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			wr_ptr_q <= wr_ptr_nxt;
			rd_ptr_q <= rd_ptr_nxt;
			cnt_q    <= cnt_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/uart_receive_fifo_overrun_unit.sv -----
// An accepted item's result is registered and shows on the master side in the next cycle.
// Throughput: one item per cycle while the master side takes each result; the single
// result register frees as it is taken, so input and output advance in the same cycle.
// The byte store is a RAM with a registered read port, read in the accept cycle.
// Reset (arst_n, asynchronous, active low) clears pointers, counter and the
// result valid flag; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
// uart_receive_fifo_overrun_unit
// Receive FIFO behind a UART with a 16-bit wrapping overrun counter.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_receive_fifo_overrun_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave side: one receive, read or clear action per item
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // rx_byte[7:0], byte_present[8], hw_overrun[9], zero
	input  wire logic [1:0]  s_tuser,  // action[1:0]
	// Master side: one result per item
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // read_valid[0], read_byte[8:1], data_ready[9],
	                                   // overrun_total[25:10], zero
);

	urfo_pkg::ctrl_t ctrl;
	urfo_pkg::byte_t ram_rd_data;
	logic            accept;

	// result register
	logic            m_valid_q;
	logic            read_valid_s1;
	logic            data_ready_s1;
	urfo_pkg::cnt_t  overrun_total_s1;

	// Accept whenever the result register is empty or drains this cycle
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	urfo_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (urfo_pkg::action_t'(s_tuser)),
		.rx_byte      (s_tdata[7:0]),
		.byte_present (s_tdata[8]),
		.hw_overrun   (s_tdata[9]),
		.ctrl         (ctrl)
	);

	// Byte store: written on a push, read on a pop. The read data register
	// only moves on a pop, so it holds a stalled result's byte.
	urfo_ram #(
		.WIDTH (urfo_pkg::BYTE_W),
		.DEPTH (urfo_pkg::RING_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctrl.wr_en),
		.wr_addr (ctrl.wr_addr),
		.wr_data (ctrl.wr_data),
		.rd_en   (ctrl.rd_en),
		.rd_addr (ctrl.rd_addr),
		.rd_data (ram_rd_data)
	);

	// Hold the result flag across stalls; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Capture the result fields of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			read_valid_s1    <= ctrl.read_valid;
			data_ready_s1    <= ctrl.data_ready;
			overrun_total_s1 <= ctrl.overrun_total;
		end
	end

	assign m_tvalid = m_valid_q;
	// Force the byte to zero when nothing was popped
	assign m_tdata  = {6'd0, overrun_total_s1, data_ready_s1,
		(read_valid_s1 ? ram_rd_data : urfo_pkg::byte_t'(0)), read_valid_s1};

	// A single item never both writes and reads the store
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr_en && ctrl.rd_en))
		else $error("store written and read by one item");

	// A pop only ever happens on a ring that holds bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en |-> ctrl.ring_nonempty)
		else $error("pop from an empty ring");

	// An accepted clear leaves a zero counter in the result
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == urfo_pkg::ACT_CLEAR)) |=> (m_tdata[25:10] == 16'd0))
		else $error("clear did not zero the overrun counter");

	// A result that popped nothing carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !read_valid_s1) |-> (m_tdata[8:1] == 8'd0))
		else $error("nonzero byte without a pop");

endmodule

`default_nettype wire

// ----- dv/tb_uart_receive_fifo_overrun_unit.sv -----
// ----------------------------------------------------------------------------
// tb_uart_receive_fifo_overrun_unit
// Self-checking bench for the UART receive FIFO with its overrun counter.
// Drives receive, read, clear and unused actions over the slave stream and
// predicts every result from a local copy of the ring and counter. Covers a
// full ring, dropped bytes and a long master-side stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uart_receive_fifo_overrun_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// Action code that the block must treat as a no-op
	localparam urfo_pkg::action_t ACT_UNUSED = 2'd3;

	// Length of the long master-side hold-off, in cycles
	localparam int HOLD_OFF_CYCLES = 64;

	// Sink behavior on m_tready
	typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	// One predicted result, in the order the fields sit on m_tdata
	typedef struct packed {
		logic            rd_valid;
		urfo_pkg::byte_t rd_byte;
		logic            ready;
		urfo_pkg::cnt_t  total;
	} fifo_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // rx_byte[7:0], byte_present[8], hw_overrun[9], zero
	logic [1:0]  s_tuser  = '0;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // read_valid[0], read_byte[8:1], data_ready[9],
	                              // overrun_total[25:10], zero

	uart_receive_fifo_overrun_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ------------------------------------------------------------------
	// Predictor state: local ring, pointers and overrun counter
	// ------------------------------------------------------------------
	urfo_pkg::byte_t ring_mem [urfo_pkg::RING_DEPTH];
	int unsigned     ring_head = 0;     // next entry to fill
	int unsigned     ring_tail = 0;     // next entry to pop
	urfo_pkg::cnt_t  pred_overrun = '0;

	fifo_result_t fifo_results_due[$];
	int           mismatch_count = 0;

	// Stimulus shaping, set by the test tasks
	bit           send_gaps_on   = 1'b0;
	int           burst_left     = 0;
	sink_mode_t   sink_mode      = SINK_ALWAYS;
	int           hold_off_requests = 0;

	// ------------------------------------------------------------------
	// Clock, limit
	// ------------------------------------------------------------------
	initial begin
		forever #10 clk = ~clk;
	end

	// Abort a hung run; the slowest correct run needs well under a tenth of this
	initial begin
		#100_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic int unsigned ring_next(input int unsigned p);
		return (p + 1 >= urfo_pkg::RING_DEPTH) ? 0 : p + 1;
	endfunction

	// Apply one accepted action to the local ring and return its result
	function automatic fifo_result_t compute_fifo_result(input urfo_pkg::action_t act,
			input urfo_pkg::byte_t data, input logic present, input logic ovr);
		fifo_result_t res;
		int unsigned  nxt;
		res = '0;
		case (act)
			urfo_pkg::ACT_RECEIVE: begin
				// overrun flag counts first, then a dropped byte counts again
				if (ovr) begin
					pred_overrun = pred_overrun + urfo_pkg::cnt_t'(1);
				end
				if (present) begin
					nxt = ring_next(ring_head);
					if (nxt != ring_tail) begin
						ring_mem[urfo_pkg::ptr_t'(ring_head)] = data;
						ring_head = nxt;
					end else begin
						pred_overrun = pred_overrun + urfo_pkg::cnt_t'(1);
					end
				end
			end
			urfo_pkg::ACT_READ: begin
				if (ring_head != ring_tail) begin
					res.rd_valid = 1'b1;
					res.rd_byte  = ring_mem[urfo_pkg::ptr_t'(ring_tail)];
					ring_tail    = ring_next(ring_tail);
				end
			end
			urfo_pkg::ACT_CLEAR: begin
				pred_overrun = '0;
			end
			default: begin
			end
		endcase
		res.ready = (ring_head != ring_tail);
		res.total = pred_overrun;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Report and result check
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin
		fifo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (fifo_results_due.size() == 0) begin
				report_mismatch("result with nothing pending", '0, m_tdata);
			end else begin
				want = fifo_results_due.pop_front();
				if (m_tdata[0] !== want.rd_valid)
					report_mismatch("read_valid", 32'(want.rd_valid), 32'(m_tdata[0]));
				if (m_tdata[8:1] !== want.rd_byte)
					report_mismatch("read_byte", 32'(want.rd_byte), 32'(m_tdata[8:1]));
				if (m_tdata[9] !== want.ready)
					report_mismatch("data_ready", 32'(want.ready), 32'(m_tdata[9]));
				if (m_tdata[25:10] !== want.total)
					report_mismatch("overrun_total", 32'(want.total), 32'(m_tdata[25:10]));
				if (m_tdata[31:26] !== '0)
					report_mismatch("tdata padding", '0, 32'(m_tdata[31:26]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Sink: stall per sink_mode (never, random or fixed pattern); serve long hold-off requests
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		static int          hold_off_served = 0;
		static int          hold_left = 0;
		static int unsigned sink_cycle = 0;
		static logic [15:0] stall_pattern = 16'b1101_1110_0111_1011;
		sink_cycle++;
		if (hold_off_served != hold_off_requests) begin
			hold_off_served = hold_off_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left != 0) begin
			// hold off while the sender keeps offering items
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			case (sink_mode)
				SINK_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
				SINK_PATTERN: m_tready <= stall_pattern[sink_cycle[3:0]];
				default:      m_tready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Send one item; called right after a rising edge
	// ------------------------------------------------------------------
	task automatic send_action(input urfo_pkg::action_t act, input urfo_pkg::byte_t data,
			input logic present, input logic ovr);
		int gap;
		if (send_gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {6'b0, ovr, present, data};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// accepted at this edge: predict in order of acceptance
		fifo_results_due.push_back(compute_fifo_result(act, data, present, ovr));
		if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	// Pop everything the ring holds
	task automatic drain_ring();
		while (ring_head != ring_tail) begin
			send_action(urfo_pkg::ACT_READ, urfo_pkg::byte_t'($urandom), 1'b0, 1'b0);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every action, and each special case
	task automatic test_directed();
		send_gaps_on = 1'b0;
		sink_mode    = SINK_ALWAYS;
		send_action(urfo_pkg::ACT_CLEAR,   8'h00, 1'b0, 1'b0);
		send_action(urfo_pkg::ACT_READ,    8'h00, 1'b0, 1'b0);   // read from an empty ring
		send_action(ACT_UNUSED,            8'hC3, 1'b1, 1'b1);   // unused code changes nothing
		send_action(urfo_pkg::ACT_RECEIVE, 8'h00, 1'b1, 1'b0);
		send_action(urfo_pkg::ACT_RECEIVE, 8'hFF, 1'b1, 1'b1);   // both flags on one event
		send_action(urfo_pkg::ACT_RECEIVE, 8'h3C, 1'b0, 1'b1);   // overrun flag without a byte
		send_action(urfo_pkg::ACT_RECEIVE, 8'hA5, 1'b0, 1'b0);   // event with nothing in it
		send_action(urfo_pkg::ACT_RECEIVE, 8'h5A, 1'b1, 1'b0);
		send_action(urfo_pkg::ACT_READ,    8'hFF, 1'b1, 1'b1);   // flags ignored on reads
		send_action(urfo_pkg::ACT_READ,    8'h00, 1'b0, 1'b0);
		send_action(urfo_pkg::ACT_READ,    8'h00, 1'b0, 1'b0);
		send_action(urfo_pkg::ACT_READ,    8'h00, 1'b0, 1'b0);   // empty again
		send_action(urfo_pkg::ACT_CLEAR,   8'hFF, 1'b1, 1'b1);
		send_action(ACT_UNUSED,            8'h00, 1'b0, 1'b0);
		send_action(urfo_pkg::ACT_RECEIVE, 8'h81, 1'b1, 1'b1);
		send_action(urfo_pkg::ACT_CLEAR,   8'h00, 1'b0, 1'b0);   // clear leaves stored bytes alone
		send_action(urfo_pkg::ACT_RECEIVE, 8'h7E, 1'b1, 1'b0);
		send_action(urfo_pkg::ACT_READ,    8'h00, 1'b0, 1'b0);
		send_action(urfo_pkg::ACT_READ,    8'h00, 1'b0, 1'b0);
		send_action(urfo_pkg::ACT_READ,    8'h00, 1'b0, 1'b0);
	endtask

	// Long master stall: the result register fills and s_tready must drop
	task automatic test_backpressure();
		send_gaps_on = 1'b0;
		sink_mode    = SINK_ALWAYS;
		hold_off_requests++;
		for (int i = 0; i < 24; i++) begin
			send_action((i % 3 == 2) ? urfo_pkg::ACT_READ : urfo_pkg::ACT_RECEIVE,
				urfo_pkg::byte_t'($urandom), 1'b1, ($urandom_range(0, 3) == 0));
		end
	endtask

	// Fill the ring to its limit, overflow it, then drain past empty
	task automatic test_fill_overflow();
		send_gaps_on = 1'b1;
		sink_mode    = SINK_RANDOM;
		drain_ring();
		for (int i = 0; i < urfo_pkg::RING_DEPTH - 1; i++) begin
			send_action(urfo_pkg::ACT_RECEIVE, urfo_pkg::byte_t'($urandom), 1'b1, 1'b0);
		end
		// ring is full: each byte now drops and counts
		for (int i = 0; i < 4; i++) begin
			send_action(urfo_pkg::ACT_RECEIVE, urfo_pkg::byte_t'($urandom), 1'b1, 1'b0);
		end
		send_action(urfo_pkg::ACT_RECEIVE, urfo_pkg::byte_t'($urandom), 1'b1, 1'b1);
		sink_mode = SINK_PATTERN;
		drain_ring();
		send_action(urfo_pkg::ACT_READ, 8'h00, 1'b0, 1'b0);
	endtask

	// Random traffic in phases that lean toward filling or draining
	task automatic test_random_traffic();
		int                recv_pct [5] = '{50, 85, 20, 60, 45};
		int                r;
		urfo_pkg::action_t act;
		for (int ph = 0; ph < 5; ph++) begin
			send_gaps_on = (ph != 3);
			sink_mode    = (ph == 3) ? SINK_ALWAYS : ((ph % 2 == 0) ? SINK_RANDOM : SINK_PATTERN);
			for (int i = 0; i < 136; i++) begin
				r = $urandom_range(0, 99);
				if (r < recv_pct[ph])
					act = urfo_pkg::ACT_RECEIVE;
				else if (r < 96)
					act = urfo_pkg::ACT_READ;
				else if (r < 98)
					act = urfo_pkg::ACT_CLEAR;
				else
					act = ACT_UNUSED;
				send_action(act, urfo_pkg::byte_t'($urandom), ($urandom_range(0, 9) != 0),
					($urandom_range(0, 9) == 0));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int guard;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_fill_overflow();
		test_random_traffic();

		// stop offering and let every pending result come out
		s_tvalid     <= 1'b0;
		sink_mode     = SINK_ALWAYS;
		guard         = 0;
		while (fifo_results_due.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		if (fifo_results_due.size() != 0) begin
			report_mismatch("results never delivered", '0, 32'(fifo_results_due.size()));
		end
		repeat (4) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
